>>> hdl/mkrt_pkg.sv
// shared types and constants of the masked key route table
`default_nettype none
package mkrt_pkg;

  localparam int GRID_X        = 8;
  localparam int GRID_Y        = 8;
  localparam int TABLE_ENTRIES = 32;

  localparam int NODE_COUNT = GRID_X * GRID_Y;
  localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);

  localparam int LINK_W        = 6;
  localparam int IN_LINK_SHIFT = 24;
  localparam int ROUTE_W       = 24;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_APPEND = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] mask;
    logic [31:0] route;
  } entry_t;

  // request travelling down the row of cells
  typedef struct packed {
    logic               active;
    op_t                op;
    logic [NODE_W-1:0]  node;
    logic [31:0]        key;
    logic [31:0]        mask;
    logic [31:0]        word;
    logic [CNT_W-1:0]   rem;
    logic               done;
    logic               appended;
    logic               hit;
    logic [ROUTE_W-1:0] found;
    status_t            status;
  } token_t;

  function automatic logic is_through_only(input logic [31:0] w);
    logic [LINK_W-1:0] out_links;
    logic [LINK_W-1:0] in_link;
    out_links = w[LINK_W-1:0];
    in_link   = w[IN_LINK_SHIFT +: LINK_W];
    return (in_link == out_links) && (w[ROUTE_W-1:LINK_W] == '0);
  endfunction

endpackage
`default_nettype wire

>>> hdl/masked_key_route_table_top.sv
// top level: request control, entry counts and the row of table cells
//
//  channel | signals                                          | direction
//  request | in_valid in_stall operation node_x node_y        | in
//          | route_key key_mask route_word                    |
//  result  | out_valid out_stall hit found_route status       | out
//
// a request passes the request registers and the table read, then one register
// per cell of the row, then the result register and the output register.
// after reset the entry counts are cleared, one node a cycle, with in_stall
// high.
// one request at a time; a new one is taken once the last result sits in
// the output register, whether or not out_stall holds it there.
`default_nettype none
module masked_key_route_table_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [2:0]  node_x,
  input  wire logic [2:0]  node_y,
  input  wire logic [31:0] route_key,
  input  wire logic [31:0] key_mask,
  input  wire logic [31:0] route_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             hit,
  output logic [23:0]      found_route,
  output logic [1:0]       status
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN, S_HOLD} state_t;

  state_t                          state;
  logic                            start;
  logic [mkrt_pkg::NODE_W-1:0]     clr_addr;
  logic                            accept;
  logic                            in_grid;
  logic [mkrt_pkg::NODE_W-1:0]     node_in;

  mkrt_pkg::op_t                   op_q;
  logic [mkrt_pkg::NODE_W-1:0]     node_q;
  logic [31:0]                     key_q;
  logic [31:0]                     mask_q;
  logic [31:0]                     word_q;
  logic                            grid_q;

  logic [mkrt_pkg::CNT_W-1:0]      cnt_mem [mkrt_pkg::NODE_COUNT];
  logic [mkrt_pkg::CNT_W-1:0]      cnt_rd;

  logic                            res_hit;
  logic [mkrt_pkg::ROUTE_W-1:0]    res_found;
  mkrt_pkg::status_t               res_status;

  mkrt_pkg::token_t                chain [mkrt_pkg::TABLE_ENTRIES+1];
  mkrt_pkg::token_t                tail;
  logic                            out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign in_grid  = (32'(node_x) < mkrt_pkg::GRID_X) && (32'(node_y) < mkrt_pkg::GRID_Y);
  assign node_in  = mkrt_pkg::NODE_W'(mkrt_pkg::NODE_W'(node_x) *
                    mkrt_pkg::NODE_W'(mkrt_pkg::GRID_Y) + mkrt_pkg::NODE_W'(node_y));
  assign tail     = chain[mkrt_pkg::TABLE_ENTRIES];
  assign out_free = !out_valid || !out_stall;

  // request registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= mkrt_pkg::op_t'(operation);
      node_q <= node_in;
      key_q  <= route_key;
      mask_q <= key_mask;
      word_q <= route_word;
      grid_q <= in_grid;
    end
  end

  // entry counts per node
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_rd <= cnt_mem[node_in];
    end
    if (state == S_CLEAR) begin
      cnt_mem[clr_addr] <= '0;
    end else if (tail.active && tail.appended) begin
      cnt_mem[node_q] <= cnt_rd + 1'b1;
    end
  end

  // token entering the first cell; off-grid requests start already settled
  always_comb begin
    chain[0].active   = start;
    chain[0].op       = op_q;
    chain[0].node     = node_q;
    chain[0].key      = key_q;
    chain[0].mask     = mask_q;
    chain[0].word     = word_q;
    chain[0].rem      = grid_q ? cnt_rd : '0;
    chain[0].done     = !grid_q;
    chain[0].appended = 1'b0;
    chain[0].hit      = 1'b0;
    chain[0].found    = '0;
    chain[0].status   = (!grid_q && op_q == mkrt_pkg::OP_INSERT) ?
                        mkrt_pkg::ST_FULL : mkrt_pkg::ST_DONE;
  end

  for (genvar g = 0; g < mkrt_pkg::TABLE_ENTRIES; g++) begin : g_cell
    mkrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .rd_en   (accept),
      .rd_node (node_in),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      start     <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      start <= accept;
      // a result waiting in S_HOLD reloads the output register itself
      if (out_valid && !out_stall && state != S_HOLD) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == mkrt_pkg::NODE_W'(mkrt_pkg::NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (tail.active) begin
            res_hit    <= tail.hit;
            res_found  <= tail.found;
            res_status <= (tail.op == mkrt_pkg::OP_INSERT && !tail.done) ?
                          mkrt_pkg::ST_FULL : tail.status;
            state      <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            hit         <= res_hit;
            found_route <= res_found;
            status      <= res_status;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_tail_only_running: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> state == S_RUN)
    else $error("request left the cell row while no request was running");

  a_start_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> start && state == S_RUN)
    else $error("accepted request did not enter the cell row");

  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mkrt_pkg::ST_FULL |-> !hit)
    else $error("dropped insert reported a hit");

  a_append_no_hit: assert property (@(posedge clk) disable iff (rst)
    tail.active && tail.appended |-> !tail.hit && tail.op == mkrt_pkg::OP_INSERT)
    else $error("append flagged together with a match or on a lookup");
`endif

endmodule
`default_nettype wire

>>> hdl/mkrt_cell.sv
// one table slot for every node, compares the passing request against its entry
`default_nettype none
module mkrt_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [mkrt_pkg::NODE_W-1:0] rd_node,
  input  wire mkrt_pkg::token_t            tok_in,
  output mkrt_pkg::token_t                 tok_out
);

  mkrt_pkg::entry_t mem [mkrt_pkg::NODE_COUNT];
  mkrt_pkg::entry_t rd_q;
  mkrt_pkg::token_t tok_next;
  logic             wr_en;
  mkrt_pkg::entry_t wr_data;
  logic             slot_used;
  logic             ins_match;
  logic             lku_match;

  always_comb begin
    tok_next  = tok_in;
    wr_en     = 1'b0;
    wr_data   = rd_q;
    slot_used = (tok_in.rem != '0);
    ins_match = ((rd_q.key & rd_q.mask) == (tok_in.key & tok_in.mask));
    lku_match = !mkrt_pkg::is_through_only(rd_q.route) &&
                ((rd_q.key & rd_q.mask) == (tok_in.key & rd_q.mask));
    if (tok_in.active && !tok_in.done) begin
      if (slot_used) begin
        if (tok_in.op == mkrt_pkg::OP_INSERT) begin
          if (ins_match) begin
            wr_en          = 1'b1;
            wr_data.route  = rd_q.route | tok_in.word;
            tok_next.done  = 1'b1;
            tok_next.hit   = 1'b1;
            tok_next.found = wr_data.route[mkrt_pkg::ROUTE_W-1:0];
            tok_next.status = mkrt_pkg::ST_DONE;
          end
        end else if (lku_match) begin
          tok_next.done   = 1'b1;
          tok_next.hit    = 1'b1;
          tok_next.found  = rd_q.route[mkrt_pkg::ROUTE_W-1:0];
          tok_next.status = mkrt_pkg::ST_DONE;
        end
      end else if (tok_in.op == mkrt_pkg::OP_INSERT) begin
        // first free slot takes the new entry
        wr_en             = 1'b1;
        wr_data.key       = tok_in.key;
        wr_data.mask      = tok_in.mask;
        wr_data.route     = tok_in.word;
        tok_next.done     = 1'b1;
        tok_next.appended = 1'b1;
        tok_next.found    = tok_in.word[mkrt_pkg::ROUTE_W-1:0];
        tok_next.status   = mkrt_pkg::ST_APPEND;
      end
    end
    tok_next.rem = slot_used ? tok_in.rem - 1'b1 : tok_in.rem;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_node];
    end
    if (wr_en) begin
      mem[tok_in.node] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule
`default_nettype wire
